// File: hw/rtl/tmx_pkg.sv
package tmx_pkg;

  localparam logic [2:0] KIND_ALLOC   = 3'd0;
  localparam logic [2:0] KIND_FREE    = 3'd1;
  localparam logic [2:0] KIND_ARM     = 3'd2;
  localparam logic [2:0] KIND_CANCEL  = 3'd3;
  localparam logic [2:0] KIND_ADVANCE = 3'd4;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  localparam int unsigned CLIENTS_RESET = 16;
  localparam int unsigned RESULT_SLOTS  = 16;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  client_id;
    logic [63:0] deadline;
    logic [63:0] period;
    logic [63:0] current_time;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  result_id;
    logic        fired;
    logic [63:0] next_deadline;
    logic        last;
    logic        more_pending;
  } res_t;

  typedef struct packed {
    logic [63:0] deadline;
    logic [63:0] period;
  } entry_t;

endpackage

// File: hw/rtl/timeout_multiplexer.sv
// Channel   Direction  Transfer when
// request   in         start && !busy (req_i)
// result    out        res_valid_o, one result per cycle (res_o)
// config    in         cfg_valid_i && cfg_ready_o (cfg_data_i)
//
// Allocate probes the flags in order, up to min(clients_in_use, MAX_CLIENTS)
// of them. Every request scans all MAX_CLIENTS entries through the single
// read port of the deadline memory; advance adds one pass per firing.
// Results follow one per cycle, each on the ports the cycle after it is
// formed. Reset and a config transfer clear all flags at once. The
// receiver cannot stall; busy drops as the last result is formed.
module timeout_multiplexer import tmx_pkg::*; #(
  parameter int unsigned MAX_CLIENTS = 16,
  parameter int unsigned MAX_FIRES   = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  req_t       req_i,
  output logic       res_valid_o,
  output res_t       res_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [4:0] cfg_data_i
);

  localparam int unsigned IW   = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int unsigned CW   = $clog2(MAX_CLIENTS + 1);
  localparam int unsigned NW   = (CW > 5) ? CW : 5;
  localparam int unsigned CAP  = (MAX_FIRES < RESULT_SLOTS) ? MAX_FIRES : RESULT_SLOTS;
  localparam int unsigned FW   = $clog2(CAP + 1);
  localparam int unsigned BW   = (CAP > 1) ? $clog2(CAP) : 1;
  localparam logic [CW-1:0] LAST_SCAN = CW'(MAX_CLIENTS);
  localparam logic [NW-1:0] MAX_N     = NW'(MAX_CLIENTS);
  localparam logic [FW-1:0] CAP_N     = FW'(CAP);

  typedef enum logic [1:0] {S_IDLE, S_ALLOC, S_SCAN, S_OUT} state_e;

  state_e          state_q;
  logic [4:0]      clients_q;
  logic            alloc_q  [MAX_CLIENTS];
  logic            active_q [MAX_CLIENTS];
  req_t            req_q;
  logic            adv_q;
  logic [1:0]      status_q;
  logic [3:0]      rid_q;
  logic [NW-1:0]   probe_q;
  logic [CW-1:0]   scan_q;
  logic            dv_q;
  logic [IW-1:0]   dv_idx_q;
  logic            best_vld_q;
  logic [IW-1:0]   best_idx_q;
  entry_t          best_q;
  logic [FW-1:0]   cnt_q;
  logic [FW-1:0]   k_q;
  logic [3:0]      buf_q [CAP];
  logic            pend_q;
  logic [63:0]     next_q;
  logic            res_valid_q;
  res_t            res_q;

  logic [NW-1:0]   usable;
  logic [NW-1:0]   id_ext;
  logic [IW-1:0]   id_idx;
  logic            in_range;
  logic            accept;
  logic            scan_done;
  logic            expired;
  logic            fire_now;
  logic            mem_wr_en;
  logic [IW-1:0]   mem_wr_addr;
  entry_t          mem_wr_data;
  logic            mem_rd_en;
  entry_t          mem_rd_data;
  logic            better;

  assign usable   = (NW'(clients_q) > MAX_N) ? MAX_N : NW'(clients_q);
  assign id_ext   = NW'(req_i.client_id);
  assign id_idx   = id_ext[IW-1:0];
  assign in_range = id_ext < usable;
  assign accept   = start && (state_q == S_IDLE);

  assign scan_done = (state_q == S_SCAN) && (scan_q == LAST_SCAN) && !dv_q;
  assign expired   = best_vld_q && (best_q.deadline <= req_q.current_time);
  assign fire_now  = scan_done && adv_q && expired && (cnt_q != CAP_N);
  assign better    = dv_q && active_q[dv_idx_q]
                     && (!best_vld_q || mem_rd_data.deadline < best_q.deadline);

  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = id_idx;
    mem_wr_data = '{deadline: req_i.deadline, period: req_i.period};
    if (accept && req_i.kind == KIND_ARM && in_range && alloc_q[id_idx]) begin
      mem_wr_en = 1'b1;
    end else if (fire_now && best_q.period != 64'd0) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = best_idx_q;
      mem_wr_data = '{deadline: best_q.deadline + best_q.period, period: best_q.period};
    end
  end

  assign mem_rd_en = (state_q == S_SCAN) && (scan_q != LAST_SCAN);

  tmx_mem #(
    .DEPTH (MAX_CLIENTS),
    .AW    (IW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (scan_q[IW-1:0]),
    .rd_data_o (mem_rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      clients_q   <= 5'(CLIENTS_RESET);
      adv_q       <= 1'b0;
      dv_q        <= 1'b0;
      best_vld_q  <= 1'b0;
      scan_q      <= '0;
      probe_q     <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < MAX_CLIENTS; i++) begin
        alloc_q[i]  <= 1'b0;
        active_q[i] <= 1'b0;
      end
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (cfg_valid_i && !start) begin
            clients_q <= cfg_data_i;
            for (int i = 0; i < MAX_CLIENTS; i++) begin
              alloc_q[i]  <= 1'b0;
              active_q[i] <= 1'b0;
            end
          end else if (start) begin
            req_q      <= req_i;
            adv_q      <= 1'b0;
            rid_q      <= 4'd0;
            cnt_q      <= '0;
            k_q        <= '0;
            pend_q     <= 1'b0;
            scan_q     <= '0;
            dv_q       <= 1'b0;
            best_vld_q <= 1'b0;
            probe_q    <= '0;
            state_q    <= (req_i.kind == KIND_ALLOC) ? S_ALLOC : S_SCAN;
            unique case (req_i.kind)
              KIND_ALLOC: begin
                status_q <= STATUS_OK;
              end
              KIND_FREE: begin
                if (in_range && alloc_q[id_idx]) begin
                  alloc_q[id_idx]  <= 1'b0;
                  active_q[id_idx] <= 1'b0;
                  status_q         <= STATUS_OK;
                end else begin
                  status_q <= STATUS_INVALID;
                end
              end
              KIND_ARM: begin
                if (in_range && alloc_q[id_idx]) begin
                  active_q[id_idx] <= 1'b1;
                  status_q         <= STATUS_OK;
                end else begin
                  status_q <= STATUS_INVALID;
                end
              end
              KIND_CANCEL: begin
                if (in_range) begin
                  active_q[id_idx] <= 1'b0;
                  status_q         <= STATUS_OK;
                end else begin
                  status_q <= STATUS_INVALID;
                end
              end
              KIND_ADVANCE: begin
                adv_q    <= 1'b1;
                status_q <= STATUS_OK;
              end
              default: begin
                status_q <= STATUS_INVALID;
              end
            endcase
          end
        end
        S_ALLOC: begin
          if (probe_q >= usable) begin
            status_q <= STATUS_FULL;
            state_q  <= S_SCAN;
          end else if (!alloc_q[probe_q[IW-1:0]]) begin
            alloc_q[probe_q[IW-1:0]] <= 1'b1;
            rid_q   <= probe_q[3:0];
            state_q <= S_SCAN;
          end else begin
            probe_q <= probe_q + NW'(1);
          end
        end
        S_SCAN: begin
          dv_q     <= mem_rd_en;
          dv_idx_q <= scan_q[IW-1:0];
          if (mem_rd_en) begin
            scan_q <= scan_q + CW'(1);
          end
          if (better) begin
            best_vld_q <= 1'b1;
            best_idx_q <= dv_idx_q;
            best_q     <= mem_rd_data;
          end
          if (scan_done) begin
            scan_q     <= '0;
            best_vld_q <= 1'b0;
            if (fire_now) begin
              buf_q[cnt_q[BW-1:0]] <= 4'(best_idx_q);
              cnt_q <= cnt_q + FW'(1);
              if (best_q.period == 64'd0) begin
                active_q[best_idx_q] <= 1'b0;
              end
            end else begin
              pend_q  <= adv_q && expired;
              next_q  <= best_vld_q ? best_q.deadline : 64'd0;
              state_q <= S_OUT;
            end
          end
        end
        S_OUT: begin
          res_valid_q         <= 1'b1;
          res_q.next_deadline <= next_q;
          res_q.more_pending  <= pend_q;
          res_q.status        <= status_q;
          res_q.result_id     <= (cnt_q != '0) ? buf_q[k_q[BW-1:0]] : rid_q;
          res_q.fired         <= (cnt_q != '0);
          res_q.last          <= (cnt_q == '0) || (k_q == cnt_q - FW'(1));
          if (cnt_q == '0 || k_q == cnt_q - FW'(1)) begin
            state_q <= S_IDLE;
          end else begin
            k_q <= k_q + FW'(1);
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE) && !start;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// File: hw/rtl/tmx_mem.sv
module tmx_mem import tmx_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  entry_t        wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output entry_t        rd_data_o
);

  entry_t mem [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import tmx_pkg::*;

  localparam int unsigned TABLE_SIZE = 16;
  localparam int unsigned FIRE_CAP   = 16;
  localparam int unsigned STALL_LIMIT = 20000;

  class timer_scoreboard;
    bit [4:0]    clients;
    bit          allocated [TABLE_SIZE];
    bit          armed [TABLE_SIZE];
    logic [63:0] deadline [TABLE_SIZE];
    logic [63:0] period [TABLE_SIZE];
    res_t        expected_q [$];
    int          errors;

    function new();
      errors = 0;
      set_clients(5'd16);
    endfunction

    function void set_clients(bit [4:0] value);
      clients = value;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        allocated[i] = 1'b0;
        armed[i]     = 1'b0;
        deadline[i]  = '0;
        period[i]    = '0;
      end
    endfunction

    function int earliest_entry();
      int best;
      best = -1;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        if (armed[i] && (best < 0 || deadline[i] < deadline[best])) best = i;
      end
      return best;
    endfunction

    function res_t make_res(logic [1:0] status, int id, logic fired);
      res_t r;
      r = '0;
      r.status    = status;
      r.result_id = id[3:0];
      r.fired     = fired;
      return r;
    endfunction

    function void note_request(req_t req);
      int          usable;
      int          id;
      int          e;
      int          fires;
      bit          in_range;
      logic        more;
      logic [63:0] next;
      res_t        batch [$];
      usable   = (clients > TABLE_SIZE) ? TABLE_SIZE : clients;
      id       = req.client_id;
      in_range = id < usable;
      more     = 1'b0;
      case (req.kind)
        KIND_ALLOC: begin
          batch.push_back(make_res(STATUS_FULL, 0, 1'b0));
          for (int i = 0; i < usable; i++) begin
            if (!allocated[i]) begin
              allocated[i] = 1'b1;
              batch[0] = make_res(STATUS_OK, i, 1'b0);
              break;
            end
          end
        end
        KIND_FREE: begin
          if (in_range && allocated[id]) begin
            armed[id]     = 1'b0;
            allocated[id] = 1'b0;
            batch.push_back(make_res(STATUS_OK, 0, 1'b0));
          end else begin
            batch.push_back(make_res(STATUS_INVALID, 0, 1'b0));
          end
        end
        KIND_ARM: begin
          if (in_range && allocated[id]) begin
            armed[id]    = 1'b1;
            deadline[id] = req.deadline;
            period[id]   = req.period;
            batch.push_back(make_res(STATUS_OK, 0, 1'b0));
          end else begin
            batch.push_back(make_res(STATUS_INVALID, 0, 1'b0));
          end
        end
        KIND_CANCEL: begin
          if (in_range) begin
            armed[id] = 1'b0;
            batch.push_back(make_res(STATUS_OK, 0, 1'b0));
          end else begin
            batch.push_back(make_res(STATUS_INVALID, 0, 1'b0));
          end
        end
        KIND_ADVANCE: begin
          fires = 0;
          while (fires < FIRE_CAP) begin
            e = earliest_entry();
            if (e < 0 || deadline[e] > req.current_time) break;
            batch.push_back(make_res(STATUS_OK, e, 1'b1));
            fires++;
            if (period[e] != 0) deadline[e] = deadline[e] + period[e];
            else armed[e] = 1'b0;
          end
          if (fires == FIRE_CAP) begin
            e = earliest_entry();
            if (e >= 0 && deadline[e] <= req.current_time) more = 1'b1;
          end
          if (fires == 0) batch.push_back(make_res(STATUS_OK, 0, 1'b0));
        end
        default: begin
          batch.push_back(make_res(STATUS_INVALID, 0, 1'b0));
        end
      endcase
      e    = earliest_entry();
      next = (e < 0) ? 64'd0 : deadline[e];
      for (int k = 0; k < batch.size(); k++) begin
        batch[k].next_deadline = next;
        batch[k].last          = (k == batch.size() - 1);
        batch[k].more_pending  = more;
        expected_q.push_back(batch[k]);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer: %p", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.result_id !== want.result_id) begin
        $error("result_id: expected %0d, actual %0d", want.result_id, got.result_id);
        errors++;
      end
      if (got.fired !== want.fired) begin
        $error("fired: expected %0d, actual %0d", want.fired, got.fired);
        errors++;
      end
      if (got.next_deadline !== want.next_deadline) begin
        $error("next_deadline: expected %0h, actual %0h", want.next_deadline,
               got.next_deadline);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
      if (got.more_pending !== want.more_pending) begin
        $error("more_pending: expected %0d, actual %0d", want.more_pending,
               got.more_pending);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  req_t       req_i;
  logic       res_valid_o;
  res_t       res_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [4:0] cfg_data_i;

  timer_scoreboard timers;
  int          idle_pct;
  int          stall_cycles;
  logic [63:0] tick;

  timeout_multiplexer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) timers.note_request(req_i);
      if (res_valid_o) timers.check_result(res_o);
      if ((start && !busy) || res_valid_o || (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic send(logic [2:0] kind, logic [3:0] id, logic [63:0] dl,
                      logic [63:0] per, logic [63:0] now);
    req_t r;
    r.kind         = kind;
    r.client_id    = id;
    r.deadline     = dl;
    r.period       = per;
    r.current_time = now;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (timers.expected_q.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_clients(logic [4:0] value);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    timers.set_clients(value);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_item();
    int          pick;
    int          usable;
    logic [3:0]  id;
    logic [63:0] dl;
    logic [63:0] per;
    pick   = $urandom_range(99);
    usable = (timers.clients > TABLE_SIZE) ? TABLE_SIZE : timers.clients;
    id     = ($urandom_range(9) == 0 || usable == 0) ? 4'($urandom_range(15))
                                                     : 4'($urandom_range(usable - 1));
    dl     = tick + $urandom_range(0, 60);
    per    = ($urandom_range(2) == 0) ? 64'd0 : 64'($urandom_range(1, 40));
    if ($urandom_range(19) == 0) dl = rand64();
    if ($urandom_range(19) == 0) per = rand64();
    if (pick < 16) begin
      send(KIND_ALLOC, 4'($urandom_range(15)), rand64(), rand64(), rand64());
    end else if (pick < 24) begin
      send(KIND_FREE, id, rand64(), rand64(), rand64());
    end else if (pick < 56) begin
      send(KIND_ARM, id, dl, per, rand64());
    end else if (pick < 64) begin
      send(KIND_CANCEL, id, rand64(), rand64(), rand64());
    end else if (pick < 97) begin
      tick = tick + $urandom_range(0, 30);
      if ($urandom_range(29) == 0) tick = rand64();
      send(KIND_ADVANCE, id, rand64(), rand64(), tick);
    end else begin
      send(3'($urandom_range(5, 7)), id, rand64(), rand64(), rand64());
    end
  endtask

  initial begin
    timers       = new();
    stall_cycles = 0;
    idle_pct     = 0;
    tick         = '0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(KIND_FREE, 4'd0, '0, '0, '0);
    send(KIND_CANCEL, 4'd15, '0, '0, '0);
    send(KIND_ARM, 4'd15, '0, '0, '0);
    send(KIND_ALLOC, 4'd0, '0, '0, '0);
    send(KIND_ALLOC, 4'd0, '0, '0, '0);
    send(KIND_ARM, 4'd0, 64'd0, 64'd0, '0);
    send(KIND_ADVANCE, 4'd0, '0, '0, 64'd0);
    send(KIND_ARM, 4'd1, 64'd0, 64'd1, '0);
    send(KIND_ADVANCE, 4'd0, '0, '0, '1);
    send(KIND_ARM, 4'd1, '1, '1, '0);
    send(KIND_ADVANCE, 4'd0, '1, '1, '1);
    send(KIND_ARM, 4'd0, 64'd5, 64'd0, '0);
    send(KIND_CANCEL, 4'd0, '0, '0, '0);
    send(KIND_FREE, 4'd1, '0, '0, '0);
    send(3'd5, 4'd0, '0, '0, '0);
    send(3'd6, 4'd0, '0, '0, '0);
    send(3'd7, 4'd15, '1, '1, '1);
    write_clients(5'd1);
    send(KIND_ALLOC, 4'd0, '0, '0, '0);
    send(KIND_ALLOC, 4'd0, '0, '0, '0);
    send(KIND_ARM, 4'd1, '0, '0, '0);
    write_clients(5'd0);
    send(KIND_ALLOC, 4'd0, '0, '0, '0);
    send(KIND_CANCEL, 4'd0, '0, '0, '0);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_clients(5'd16);
        1: write_clients(5'd31);
        2: write_clients(5'd5);
        3: write_clients(5'd1);
        4: write_clients(5'd0);
        default: write_clients(5'd16);
      endcase
      tick = '0;
      for (int n = 0; n < 80; n++) begin
        case ((n / 20 + phase) % 4)
          0: idle_pct = 0;
          1: idle_pct = 72;
          2: idle_pct = 0;
          default: idle_pct = 6;
        endcase
        if (n == 40) drain();
        random_item();
      end
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (timers.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
